// ----- hdl/lph_pkg.sv -----
`default_nettype none
package lph_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);

    localparam int KEY_BITS       = 64;
    localparam int HALF_BITS      = KEY_BITS / 2;
    localparam int FIELD_VAL_BITS = 16;
    localparam int INDEX_OUT_BITS = 10;
    localparam int COUNT_BITS     = 11;

    localparam logic [KEY_BITS-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_BITS-1:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int SHIFT_FIRST  = 30;
    localparam int SHIFT_MID    = 27;
    localparam int SHIFT_LAST   = 31;

    localparam int DIGIT_BITS   = 4;
    localparam int DIV_STEPS    = KEY_BITS / DIGIT_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    typedef logic [KEY_BITS-1:0]       key_t;
    typedef logic [VALUE_BITS-1:0]     payload_t;
    typedef logic [IDX_BITS-1:0]       idx_t;
    typedef logic [COUNT_BITS-1:0]     count_t;
    typedef logic [FIELD_VAL_BITS-1:0] value_t;
    typedef logic [INDEX_OUT_BITS-1:0] index_out_t;
    typedef logic [DIV_CNT_BITS-1:0]   div_cnt_t;

    localparam count_t BUCKET_COUNT_RESET = 11'd1024;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_CLEAR,
        DP_LOAD,
        DP_MUL_LL,
        DP_MUL_LH,
        DP_MUL_HL,
        DP_MUL_END,
        DP_XOR_MID,
        DP_XOR_END,
        DP_DIV_STEP,
        DP_PROBE_START,
        DP_READ,
        DP_CHECK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   const_b;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
        logic check_done;
    } dp_stat_t;

    typedef struct packed {
        logic     valid;
        key_t     key;
        payload_t payload;
    } entry_t;

endpackage
`default_nettype wire

// ----- hdl/lph_req_if.sv -----
`default_nettype none
interface lph_req_if;
    logic               valid;
    logic               ready;
    logic               operation;
    lph_pkg::key_t      key;
    lph_pkg::value_t    entry_value;

    modport source (output valid, operation, key, entry_value, input ready);
    modport sink   (input valid, operation, key, entry_value, output ready);
endinterface
`default_nettype wire

// ----- hdl/lph_rsp_if.sv -----
`default_nettype none
interface lph_rsp_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    lph_pkg::value_t       found_value;
    lph_pkg::index_out_t   bucket_index;

    modport source (output valid, status, found_value, bucket_index, input ready);
    modport sink   (input valid, status, found_value, bucket_index, output ready);
endinterface
`default_nettype wire

// ----- hdl/lph_datapath.sv -----
`default_nettype none
module lph_datapath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  lph_pkg::dp_cmd_t      cmd,
    output lph_pkg::dp_stat_t     stat,
    input  wire                   cfg_wr_en,
    input  lph_pkg::count_t       cfg_wr_data,
    input  wire                   in_operation,
    input  lph_pkg::key_t         in_key,
    input  lph_pkg::value_t       in_entry_value,
    input  wire                   out_ready,
    output logic                  out_valid,
    output logic [1:0]            out_status,
    output lph_pkg::value_t       out_found_value,
    output lph_pkg::index_out_t   out_bucket_index
);

    lph_pkg::entry_t   mem [lph_pkg::TABLE_DEPTH];
    lph_pkg::entry_t   rd_reg;
    lph_pkg::entry_t   mem_wdata;
    logic              mem_we;

    lph_pkg::count_t   bucket_count_reg;
    lph_pkg::idx_t     j_reg, j_next;
    logic              out_valid_reg, out_valid_next;

    logic              op_reg;
    lph_pkg::key_t     key_reg;
    lph_pkg::payload_t payload_reg;
    lph_pkg::count_t   n_reg, n_next;
    lph_pkg::key_t     x_reg, x_next;
    lph_pkg::key_t     acc_reg, acc_next;
    lph_pkg::key_t     prod_reg;
    lph_pkg::count_t   rem_reg, rem_next;
    lph_pkg::count_t   probes_reg, probes_next;

    lph_pkg::status_t    status_reg, status_next;
    lph_pkg::value_t     found_reg, found_next;
    lph_pkg::index_out_t index_reg, index_next;

    lph_pkg::key_t     mul_const;
    logic [lph_pkg::HALF_BITS-1:0] mul_a, mul_b;
    lph_pkg::key_t     mul_p;
    lph_pkg::key_t     cross_sum;

    logic              hit_empty, hit_key, last_probe, stop, check_fire;

    // multiplier operand select: one 32x32 product per cycle
    always_comb
    begin
        mul_const = cmd.const_b ? lph_pkg::MIX_MUL_B : lph_pkg::MIX_MUL_A;
        mul_a     = x_reg[lph_pkg::HALF_BITS-1:0];
        mul_b     = mul_const[lph_pkg::HALF_BITS-1:0];
        case (cmd.op)
            lph_pkg::DP_MUL_LH:
            begin
                mul_b = mul_const[lph_pkg::KEY_BITS-1:lph_pkg::HALF_BITS];
            end
            lph_pkg::DP_MUL_HL:
            begin
                mul_a = x_reg[lph_pkg::KEY_BITS-1:lph_pkg::HALF_BITS];
            end
            default:
            begin
            end
        endcase
        mul_p     = lph_pkg::key_t'(mul_a) * lph_pkg::key_t'(mul_b);
        cross_sum = {prod_reg[lph_pkg::HALF_BITS-1:0], {lph_pkg::HALF_BITS{1'b0}}};
    end

    // probe evaluation
    always_comb
    begin
        hit_empty  = !rd_reg.valid;
        hit_key    = rd_reg.valid && (rd_reg.key == key_reg);
        last_probe = (probes_reg == n_reg - lph_pkg::count_t'(1));
        stop       = (op_reg == lph_pkg::OP_LOOKUP) ? (hit_empty || hit_key) : hit_empty;
        check_fire = (cmd.op == lph_pkg::DP_CHECK);

        status_next = lph_pkg::ST_FULL;
        if (op_reg == lph_pkg::OP_INSERT)
        begin
            if (hit_empty)
                status_next = lph_pkg::ST_INSERTED;
        end
        else
        begin
            if (hit_empty)
                status_next = lph_pkg::ST_NOT_FOUND;
            else if (hit_key)
                status_next = lph_pkg::ST_FOUND;
        end
        found_next = (status_next == lph_pkg::ST_FOUND) ?
                     lph_pkg::value_t'(rd_reg.payload) : '0;
        index_next = (status_next == lph_pkg::ST_FOUND || status_next == lph_pkg::ST_INSERTED) ?
                     lph_pkg::index_out_t'(j_reg) : '0;

        stat.check_done = stop || last_probe;
        stat.out_busy   = out_valid_reg && !out_ready;
        stat.clear_last = (j_reg == lph_pkg::idx_t'(lph_pkg::TABLE_DEPTH - 1));

        mem_we    = (cmd.op == lph_pkg::DP_CLEAR) ||
                    (check_fire && op_reg == lph_pkg::OP_INSERT && hit_empty);
        mem_wdata = '0;
        if (cmd.op != lph_pkg::DP_CLEAR)
        begin
            mem_wdata.valid   = 1'b1;
            mem_wdata.key     = key_reg;
            mem_wdata.payload = payload_reg;
        end
    end

    // index, hash and modulo next values
    always_comb
    begin
        logic [lph_pkg::COUNT_BITS:0] trial;
        lph_pkg::count_t              r;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !out_ready;
        n_next         = n_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        probes_next    = probes_reg;
        r              = rem_reg;
        trial          = '0;

        if (bucket_count_reg == '0)
            n_next = lph_pkg::count_t'(1);
        else if (32'(bucket_count_reg) > lph_pkg::TABLE_DEPTH)
            n_next = lph_pkg::count_t'(lph_pkg::TABLE_DEPTH);
        else
            n_next = bucket_count_reg;
        if (cmd.op != lph_pkg::DP_LOAD)
            n_next = n_reg;

        case (cmd.op)
            lph_pkg::DP_CLEAR:
            begin
                j_next = j_reg + lph_pkg::idx_t'(1);
            end
            lph_pkg::DP_LOAD:
            begin
                x_next = in_key ^ (in_key >> lph_pkg::SHIFT_FIRST);
            end
            lph_pkg::DP_MUL_LH:
            begin
                acc_next = prod_reg;
            end
            lph_pkg::DP_MUL_HL, lph_pkg::DP_MUL_END:
            begin
                acc_next = acc_reg + cross_sum;
            end
            lph_pkg::DP_XOR_MID:
            begin
                x_next = acc_reg ^ (acc_reg >> lph_pkg::SHIFT_MID);
            end
            lph_pkg::DP_XOR_END:
            begin
                x_next   = acc_reg ^ (acc_reg >> lph_pkg::SHIFT_LAST);
                rem_next = '0;
            end
            lph_pkg::DP_DIV_STEP:
            begin
                for (int i = 0; i < lph_pkg::DIGIT_BITS; i++)
                begin
                    trial = {r, x_reg[lph_pkg::KEY_BITS-1-i]};
                    if (trial >= {1'b0, n_reg})
                        trial = trial - {1'b0, n_reg};
                    r = trial[lph_pkg::COUNT_BITS-1:0];
                end
                rem_next = r;
                x_next   = x_reg << lph_pkg::DIGIT_BITS;
            end
            lph_pkg::DP_PROBE_START:
            begin
                j_next      = lph_pkg::idx_t'(rem_reg);
                probes_next = '0;
            end
            lph_pkg::DP_CHECK:
            begin
                if (stop || last_probe)
                    out_valid_next = 1'b1;
                else
                begin
                    probes_next = probes_reg + lph_pkg::count_t'(1);
                    if (lph_pkg::count_t'(j_reg) + lph_pkg::count_t'(1) == n_reg)
                        j_next = '0;
                    else
                        j_next = j_reg + lph_pkg::idx_t'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= lph_pkg::BUCKET_COUNT_RESET;
            j_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                bucket_count_reg <= cfg_wr_data;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == lph_pkg::DP_LOAD)
        begin
            op_reg      <= in_operation;
            key_reg     <= in_key;
            payload_reg <= lph_pkg::payload_t'(in_entry_value);
        end
        n_reg      <= n_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        prod_reg   <= mul_p;
        rem_reg    <= rem_next;
        probes_reg <= probes_next;
        if (check_fire && stat.check_done)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            index_reg  <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[j_reg] <= mem_wdata;
        if (cmd.op == lph_pkg::DP_READ)
            rd_reg <= mem[j_reg];
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = status_reg;
    assign out_found_value  = found_reg;
    assign out_bucket_index = index_reg;

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        check_fire |-> (j_reg < n_reg && probes_reg < n_reg))
        else $error("probe index or count outside buckets in use");

    a_insert_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (check_fire && mem_we) |=> (out_valid_reg && status_reg == lph_pkg::ST_INSERTED))
        else $error("bucket written without an inserted result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(check_fire))
        else $error("result raised outside a probe check");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == lph_pkg::DP_CLEAR) |-> !out_valid_reg)
        else $error("result pending during clearing pass");

endmodule
`default_nettype wire

// ----- hdl/lph_controller.sv -----
`default_nettype none
module lph_controller (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output lph_pkg::dp_cmd_t    cmd,
    input  lph_pkg::dp_stat_t   stat
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_LL,
        S_MUL_LH,
        S_MUL_HL,
        S_MUL_END,
        S_XOR_MID,
        S_XOR_END,
        S_DIV,
        S_PROBE,
        S_READ,
        S_CHECK
    } state_t;

    state_t              state_reg, state_next;
    logic                pass_b_reg, pass_b_next;
    lph_pkg::div_cnt_t   div_cnt_reg, div_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        pass_b_next  = pass_b_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = lph_pkg::DP_IDLE;
        cmd.const_b  = pass_b_reg;
        in_ready     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = lph_pkg::DP_CLEAR;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op      = lph_pkg::DP_LOAD;
                    pass_b_next = 1'b0;
                    state_next  = S_MUL_LL;
                end
            end
            S_MUL_LL:
            begin
                cmd.op     = lph_pkg::DP_MUL_LL;
                state_next = S_MUL_LH;
            end
            S_MUL_LH:
            begin
                cmd.op     = lph_pkg::DP_MUL_LH;
                state_next = S_MUL_HL;
            end
            S_MUL_HL:
            begin
                cmd.op     = lph_pkg::DP_MUL_HL;
                state_next = S_MUL_END;
            end
            S_MUL_END:
            begin
                cmd.op     = lph_pkg::DP_MUL_END;
                state_next = pass_b_reg ? S_XOR_END : S_XOR_MID;
            end
            S_XOR_MID:
            begin
                cmd.op      = lph_pkg::DP_XOR_MID;
                pass_b_next = 1'b1;
                state_next  = S_MUL_LL;
            end
            S_XOR_END:
            begin
                cmd.op       = lph_pkg::DP_XOR_END;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.op       = lph_pkg::DP_DIV_STEP;
                div_cnt_next = div_cnt_reg + lph_pkg::div_cnt_t'(1);
                if (div_cnt_reg == lph_pkg::div_cnt_t'(lph_pkg::DIV_STEPS - 1))
                    state_next = S_PROBE;
            end
            S_PROBE:
            begin
                cmd.op     = lph_pkg::DP_PROBE_START;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.op     = lph_pkg::DP_READ;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = lph_pkg::DP_CHECK;
                    state_next = stat.check_done ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            pass_b_reg  <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pass_b_reg  <= pass_b_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/linear_probe_hash_table.sv -----
// Linear-probing hash table, 64-bit keys, 16-bit values.
// request: valid/ready channel carrying operation (0 insert, 1 lookup), key and
//   entry_value. One word is taken at an edge with valid and ready high.
// result: valid/ready channel carrying status (0 inserted, 1 found, 2 not found,
//   3 table full), found_value and bucket_index; one result word per request.
// cfg_wr_en/cfg_wr_data write bucket_count (0 acts as 1, above the table
//   depth saturates); write only while no request is in flight.
// Hashing after the accepting edge: two 64-bit multiplies, each as three 32x32
//   partial products in states MUL_LL, MUL_LH, MUL_HL and MUL_END, two
//   xor-shifts, a 4-bit-per-cycle remainder in the DIV steps, and a load of the
//   home bucket in PROBE; then for each bucket probed a registered table read,
//   then a compare. One request at a time: the shared multiplier, the
//   remainder unit and the single read port serve one request, and the next
//   is accepted only once the last compare of the current one has finished.
// Reset: bucket_count returns to 1024 and a clearing pass writes every bucket
//   empty with request.ready low; configuration is taken meanwhile.
// Stall: a finished result waits in the output register; the next request is
//   accepted and hashed, and holds at its first compare until the register frees.
`default_nettype none
module linear_probe_hash_table (
    input  wire               clk,
    input  wire               rst_n,
    lph_req_if.sink           request,
    lph_rsp_if.source         result,
    input  wire               cfg_wr_en,
    input  lph_pkg::count_t   cfg_wr_data
);

    lph_pkg::dp_cmd_t   cmd;
    lph_pkg::dp_stat_t  stat;
    logic               in_ready;

    lph_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lph_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_operation     (request.operation),
        .in_key           (request.key),
        .in_entry_value   (request.entry_value),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_status       (result.status),
        .out_found_value  (result.found_value),
        .out_bucket_index (result.bucket_index)
    );

    assign request.ready = in_ready;

endmodule
`default_nettype wire

// ----- sim/lph_result_checker.sv -----
`timescale 1ns / 1ps
module lph_result_checker (
    input  logic            clk,
    input  logic            rst_n,
    lph_req_if              request,
    lph_rsp_if              result,
    input  logic            cfg_wr_en,
    input  lph_pkg::count_t cfg_wr_data,
    output int              mismatch_count,
    output int              outstanding
);

    typedef struct packed {
        lph_pkg::status_t    status;
        lph_pkg::value_t     value;
        lph_pkg::index_out_t index;
    } outcome_t;

    lph_pkg::count_t   bucket_count;
    logic              occupied [lph_pkg::TABLE_DEPTH];
    lph_pkg::key_t     stored_key [lph_pkg::TABLE_DEPTH];
    lph_pkg::payload_t stored_payload [lph_pkg::TABLE_DEPTH];
    outcome_t          awaited_outcomes [$];
    outcome_t          want;

    function automatic lph_pkg::key_t mix_key(lph_pkg::key_t k);
        k = k ^ (k >> lph_pkg::SHIFT_FIRST);
        k = k * lph_pkg::MIX_MUL_A;
        k = k ^ (k >> lph_pkg::SHIFT_MID);
        k = k * lph_pkg::MIX_MUL_B;
        k = k ^ (k >> lph_pkg::SHIFT_LAST);
        return k;
    endfunction

    // applies one insert or lookup to the shadow table
    function automatic outcome_t probe_table(logic op, lph_pkg::key_t k, lph_pkg::value_t v);
        int span;
        int slot;
        outcome_t res;
        if (bucket_count == 0)
            span = 1;
        else if (bucket_count > lph_pkg::TABLE_DEPTH)
            span = lph_pkg::TABLE_DEPTH;
        else
            span = int'(bucket_count);
        slot = int'(mix_key(k) % lph_pkg::key_t'(span));
        res = '0;
        res.status = lph_pkg::ST_FULL;
        for (int p = 0; p < span; p++)
        begin
            if (op == lph_pkg::OP_INSERT)
            begin
                if (!occupied[slot])
                begin
                    occupied[slot] = 1'b1;
                    stored_key[slot] = k;
                    stored_payload[slot] = lph_pkg::payload_t'(v);
                    res.status = lph_pkg::ST_INSERTED;
                    res.index = lph_pkg::index_out_t'(slot);
                    return res;
                end
            end
            else
            begin
                if (!occupied[slot])
                begin
                    res.status = lph_pkg::ST_NOT_FOUND;
                    return res;
                end
                if (stored_key[slot] == k)
                begin
                    res.status = lph_pkg::ST_FOUND;
                    res.value = lph_pkg::value_t'(stored_payload[slot]);
                    res.index = lph_pkg::index_out_t'(slot);
                    return res;
                end
            end
            slot = (slot + 1) % span;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count = lph_pkg::BUCKET_COUNT_RESET;
            for (int i = 0; i < lph_pkg::TABLE_DEPTH; i++)
                occupied[i] = 1'b0;
            awaited_outcomes.delete();
            mismatch_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en === 1'b1)
                bucket_count = cfg_wr_data;
            if (result.valid === 1'b1 && result.ready === 1'b1)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $display("%0t: expected no word, got status %0d value %h index %0d",
                             $time, result.status, result.found_value, result.bucket_index);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (result.status !== want.status || result.found_value !== want.value ||
                        result.bucket_index !== want.index)
                    begin
                        $display("%0t: expected %0d %h %0d, got %0d %h %0d (status value index)",
                                 $time, want.status, want.value, want.index,
                                 result.status, result.found_value, result.bucket_index);
                        mismatch_count++;
                    end
                end
            end
            if (request.valid === 1'b1 && request.ready === 1'b1)
                awaited_outcomes.push_back(probe_table(request.operation, request.key,
                                                       request.entry_value));
            outstanding <= awaited_outcomes.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int NUM_DIRECTED  = 15;
    localparam int NUM_PHASES    = 12;

    localparam logic DIR_OP [NUM_DIRECTED] = '{
        lph_pkg::OP_INSERT, lph_pkg::OP_INSERT, lph_pkg::OP_LOOKUP, lph_pkg::OP_LOOKUP,
        lph_pkg::OP_LOOKUP, lph_pkg::OP_INSERT, lph_pkg::OP_LOOKUP, lph_pkg::OP_INSERT,
        lph_pkg::OP_INSERT, lph_pkg::OP_LOOKUP, lph_pkg::OP_LOOKUP, lph_pkg::OP_INSERT,
        lph_pkg::OP_LOOKUP, lph_pkg::OP_INSERT, lph_pkg::OP_LOOKUP
    };
    localparam lph_pkg::key_t DIR_KEY [NUM_DIRECTED] = '{
        64'h0, 64'hffff_ffff_ffff_ffff, 64'h0, 64'hffff_ffff_ffff_ffff,
        64'h0123_4567_89ab_cdef, 64'h0, 64'h0,
        64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
        64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h1, 64'h1
    };
    localparam lph_pkg::value_t DIR_VAL [NUM_DIRECTED] = '{
        16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'h0000,
        16'h1234, 16'h0000, 16'haaaa, 16'h5555, 16'h0000,
        16'h0000, 16'h8000, 16'h0000, 16'h0001, 16'h0000
    };

    // bucket count per phase, mostly growing so the table fills gradually; 0 and 2047 hit the clamps
    localparam int PHASE_COUNT [NUM_PHASES] = '{
        1, 0, 2, 3, 5, 16, 61, 200, 1024, 2047, 97, 1024
    };
    localparam int PHASE_ITEMS [NUM_PHASES] = '{
        30, 20, 30, 30, 30, 60, 80, 200, 300, 250, 60, 100
    };

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    lph_pkg::count_t cfg_wr_data;
    logic            steady;
    int              mismatch_count;
    int              outstanding;
    int              cycle_count = 0;
    lph_pkg::key_t   known_keys [$];

    lph_req_if req ();
    lph_rsp_if rsp ();

    linear_probe_hash_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (req),
        .result      (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lph_result_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (req),
        .result         (rsp),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result backpressure
    initial
    begin
        int hold;
        hold = 0;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                rsp.ready <= 1'b0;
                hold--;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                rsp.ready <= 1'b0;
                hold = $urandom_range(0, 2);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // leaves valid high on return
    task automatic send_word(logic op, lph_pkg::key_t k, lph_pkg::value_t v);
        req.valid       <= 1'b1;
        req.operation   <= op;
        req.key         <= k;
        req.entry_value <= v;
        do @(posedge clk); while (req.ready !== 1'b1);
    endtask

    task automatic pause_sender();
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_bucket_count(lph_pkg::count_t c);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly inserts and lookups of stored keys, some duplicates and misses
    task automatic random_word();
        int            pick;
        lph_pkg::key_t k;
        logic          op;
        pick = $urandom_range(0, 99);
        k = {$urandom, $urandom};
        op = lph_pkg::OP_LOOKUP;
        if (pick < 45)
        begin
            op = lph_pkg::OP_INSERT;
            if (pick < 5 && known_keys.size() > 0)
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else if (pick == 5)
                k = '0;
            else if (pick == 6)
                k = '1;
            known_keys.push_back(k);
        end
        else if (pick < 82 && known_keys.size() > 0)
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        send_word(op, k, lph_pkg::value_t'($urandom));
        pause_sender();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.operation   <= lph_pkg::OP_INSERT;
        req.key         <= '0;
        req.entry_value <= '0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= lph_pkg::BUCKET_COUNT_RESET;
        steady = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_word(DIR_OP[i], DIR_KEY[i], DIR_VAL[i]);
            if (DIR_OP[i] == lph_pkg::OP_INSERT)
                known_keys.push_back(DIR_KEY[i]);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            steady = (p == NUM_PHASES - 1) || ($urandom_range(0, 3) == 0);
            set_bucket_count(lph_pkg::count_t'(PHASE_COUNT[p]));
            repeat (PHASE_ITEMS[p]) random_word();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lph_pkg.sv
hdl/lph_req_if.sv
hdl/lph_rsp_if.sv
hdl/lph_datapath.sv
hdl/lph_controller.sv
hdl/linear_probe_hash_table.sv
sim/lph_result_checker.sv
sim/tb_top.sv
